// ----- sv/bmla_pkg.sv -----
// Shared types, widths and constants of the BLER-driven MCS link adaptation block.
`timescale 1ns / 1ps

package bmla_pkg;

  // Field widths
  localparam int SLOT_W   = 6;
  localparam int FRAME_W  = 10;   // frame numbers wrap at 2**FRAME_W
  localparam int MCS_W    = 5;
  localparam int BLER_W   = 16;
  localparam int CNT_W    = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int NUM_IN_SLOTS      = 2 ** SLOT_W;
  localparam int NUM_LINKS_DEFAULT = 64;

  // Algorithm constants
  localparam logic [MCS_W-1:0]  INIT_MCS          = 5'd9;
  localparam logic [MCS_W-1:0]  MIN_STEP_DOWN_MCS = 5'd6;
  localparam logic [CNT_W-1:0]  MIN_ACTIVE_SCHED  = 32'd3;
  localparam logic [BLER_W:0]   Q16_ONE           = 17'h10000;
  localparam logic [BLER_W*2:0] Q16_ROUND         = 33'h000008000;
  localparam logic [BLER_W-1:0] BLER_FULL         = 16'hFFFF;
  localparam int                DIV_STEPS         = BLER_W;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BLER_LOW    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLER_HIGH   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MCS_CEILING = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_WT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UPD_INTERVAL = 3'd4;

  // Configuration reset values
  localparam logic [BLER_W-1:0]  RST_BLER_LOW     = 16'd3277;
  localparam logic [BLER_W-1:0]  RST_BLER_HIGH    = 16'd6554;
  localparam logic [MCS_W-1:0]   RST_MCS_CEILING  = 5'd28;
  localparam logic [BLER_W-1:0]  RST_FILTER_WT    = 16'd58982;
  localparam logic [FRAME_W-1:0] RST_UPD_INTERVAL = 10'd10;

  // One link's state word
  typedef struct packed {
    logic               valid;
    logic [FRAME_W-1:0] upd_frame;
    logic [MCS_W-1:0]   mcs;
    logic [BLER_W-1:0]  bler;
    logic [CNT_W-1:0]   saved_first_tx;
    logic [CNT_W-1:0]   saved_retx;
  } link_entry_t;

endpackage

// ----- sv/bler_mcs_link_adaptation.sv -----
// Top level: per-link outer-loop MCS adaptation with filtered BLER.
`timescale 1ns / 1ps

// Each transaction names a link slot; the block reads that link's state word, decides
// whether the update interval has elapsed, and writes the word back before it takes the
// next transaction. An item inside the interval passes from acceptance through the
// memory read and the evaluation to a result in the output register. An item that
// updates goes through a bit-serial divide of retransmissions over first transmissions,
// then the filter's multiply states ST_MUL_A and ST_MUL_B, a sum, the step decision and the
// write-back (items with no transmissions or saturated error rate skip the divide). The
// output register holds one result, so a new transaction is taken while the previous
// result waits. After reset the block clears every entry of its link memory with
// in_ready low; configuration writes are taken throughout. Slot numbers are reduced
// modulo NUM_LINKS.

module bler_mcs_link_adaptation #(
  parameter int NUM_LINKS = bmla_pkg::NUM_LINKS_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  // configuration
  input  logic                               cfg_we,
  input  logic [bmla_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bmla_pkg::CFG_DATA_W-1:0]    cfg_data,
  // input channel
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [bmla_pkg::SLOT_W-1:0]        link_slot,
  input  logic [bmla_pkg::FRAME_W-1:0]       frame_number,
  input  logic [bmla_pkg::MCS_W-1:0]         mcs_cap,
  input  logic [bmla_pkg::CNT_W-1:0]         first_tx_total,
  input  logic [bmla_pkg::CNT_W-1:0]         retx_total,
  // output channel
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [bmla_pkg::MCS_W-1:0]         chosen_mcs,
  output logic                               was_updated,
  output logic [bmla_pkg::BLER_W-1:0]        bler_average
);

  localparam int SW = (NUM_LINKS > 1) ? $clog2(NUM_LINKS) : 1;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_EVAL, ST_PREP, ST_DIV,
    ST_MUL_A, ST_MUL_B, ST_SUM, ST_DECIDE, ST_WRITE
  } state_t;

  // Configuration registers
  logic [bmla_pkg::BLER_W-1:0]  bler_low;
  logic [bmla_pkg::BLER_W-1:0]  bler_high;
  logic [bmla_pkg::MCS_W-1:0]   mcs_ceiling;
  logic [bmla_pkg::BLER_W-1:0]  filter_weight;
  logic [bmla_pkg::FRAME_W-1:0] update_interval;

  always_ff @(posedge clk) begin
    if (rst) begin
      bler_low        <= bmla_pkg::RST_BLER_LOW;
      bler_high       <= bmla_pkg::RST_BLER_HIGH;
      mcs_ceiling     <= bmla_pkg::RST_MCS_CEILING;
      filter_weight   <= bmla_pkg::RST_FILTER_WT;
      update_interval <= bmla_pkg::RST_UPD_INTERVAL;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bmla_pkg::REG_BLER_LOW:     bler_low        <= cfg_data;
        bmla_pkg::REG_BLER_HIGH:    bler_high       <= cfg_data;
        bmla_pkg::REG_MCS_CEILING:  mcs_ceiling     <= cfg_data[bmla_pkg::MCS_W-1:0];
        bmla_pkg::REG_FILTER_WT:    filter_weight   <= cfg_data;
        bmla_pkg::REG_UPD_INTERVAL: update_interval <= cfg_data[bmla_pkg::FRAME_W-1:0];
        default: ;
      endcase
    end
  end

  // Slot reduction table, worked out at elaboration
  logic [SW-1:0] slot_tab [bmla_pkg::NUM_IN_SLOTS];

  for (genvar i = 0; i < bmla_pkg::NUM_IN_SLOTS; i++) begin : g_slot_tab
    assign slot_tab[i] = SW'(i % NUM_LINKS);
  end

  state_t state;

  // Captured item
  logic [SW-1:0]                slot_r;
  logic [bmla_pkg::FRAME_W-1:0] frame_r;
  logic [bmla_pkg::MCS_W-1:0]   cap_r;
  logic [bmla_pkg::CNT_W-1:0]   first_r;
  logic [bmla_pkg::CNT_W-1:0]   retx_in_r;

  // Working registers
  bmla_pkg::link_entry_t        ent_r;
  logic [bmla_pkg::MCS_W-1:0]   old_r;
  logic [bmla_pkg::CNT_W-1:0]   sched_r;
  logic [bmla_pkg::CNT_W-1:0]   retx_r;
  logic [bmla_pkg::BLER_W-1:0]  win_r;
  logic [bmla_pkg::BLER_W*2:0]  prod_r;
  logic [bmla_pkg::BLER_W*2:0]  acc_r;
  logic [SW-1:0]                clr_idx;

  // Result register
  logic [bmla_pkg::MCS_W-1:0]   res_mcs;
  logic                         res_upd;
  logic [bmla_pkg::BLER_W-1:0]  res_avg;

  // Memory ports
  logic                         ram_we;
  logic [SW-1:0]                ram_waddr;
  bmla_pkg::link_entry_t        ram_wdata;
  logic [SW-1:0]                ram_raddr;
  bmla_pkg::link_entry_t        ram_rdata;

  // Divider ports
  logic                         div_start;
  logic                         div_done;
  logic [bmla_pkg::BLER_W-1:0]  div_q;

  // Combinational helpers
  logic                         in_fire;
  logic                         out_free;
  logic [bmla_pkg::MCS_W-1:0]   cap_in;
  logic [bmla_pkg::BLER_W:0]    mid_sum;
  bmla_pkg::link_entry_t        ent_eff;
  logic [bmla_pkg::MCS_W-1:0]   old_eval;
  logic [bmla_pkg::FRAME_W-1:0] frame_diff;
  logic [bmla_pkg::BLER_W:0]    keep_wt;
  logic [bmla_pkg::BLER_W*2-1:0] mul_a;
  logic [bmla_pkg::BLER_W*2:0]  mul_b;
  logic [bmla_pkg::BLER_W-1:0]  avg_new;
  logic                         step_up;
  logic                         step_down;
  logic [bmla_pkg::MCS_W-1:0]   mcs_new;

  assign in_ready  = (state == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;

  always_comb begin
    cap_in  = (mcs_cap < mcs_ceiling) ? mcs_cap : mcs_ceiling;
    mid_sum = {1'b0, bler_low} + {1'b0, bler_high};

    // A link never used starts at the initial MCS with BLER between the thresholds
    ent_eff = ram_rdata;
    if (!ram_rdata.valid) begin
      ent_eff.valid      = 1'b1;
      ent_eff.upd_frame  = frame_r;
      ent_eff.mcs        = bmla_pkg::INIT_MCS;
      ent_eff.bler       = mid_sum[bmla_pkg::BLER_W:1];
    end
    old_eval   = (ent_eff.mcs < cap_r) ? ent_eff.mcs : cap_r;
    frame_diff = frame_r - ent_eff.upd_frame;

    keep_wt = bmla_pkg::Q16_ONE - {1'b0, filter_weight};
    mul_a   = filter_weight * ent_r.bler;
    mul_b   = keep_wt * win_r;

    avg_new = acc_r[bmla_pkg::BLER_W*2] ? bmla_pkg::BLER_FULL
                                        : acc_r[bmla_pkg::BLER_W*2-1:bmla_pkg::BLER_W];
    step_up   = (avg_new < bler_low) && (old_r < cap_r) &&
                (sched_r > bmla_pkg::MIN_ACTIVE_SCHED);
    step_down = ((avg_new > bler_high) && (old_r > bmla_pkg::MIN_STEP_DOWN_MCS)) ||
                ((sched_r <= bmla_pkg::MIN_ACTIVE_SCHED) && (old_r > bmla_pkg::INIT_MCS));
    priority if (step_up) begin
      mcs_new = old_r + 1'b1;
    end else if (step_down) begin
      mcs_new = old_r - 1'b1;
    end else begin
      mcs_new = old_r;
    end

    div_start = (state == ST_PREP) && (sched_r != '0) && (retx_r < sched_r);

    ram_raddr = (state == ST_IDLE) ? slot_tab[link_slot] : slot_r;
    ram_we    = (state == ST_CLEAR) || ((state == ST_WRITE) && out_free);
    ram_waddr = (state == ST_CLEAR) ? clr_idx : slot_r;
    ram_wdata = (state == ST_CLEAR) ? '0 : ent_r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_idx   <= '0;
      out_valid <= 1'b0;
    end else begin
      if ((state == ST_WRITE) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == SW'(NUM_LINKS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_fire) begin
            slot_r    <= slot_tab[link_slot];
            frame_r   <= frame_number;
            cap_r     <= cap_in;
            first_r   <= first_tx_total;
            retx_in_r <= retx_total;
            state     <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          ent_r   <= ent_eff;
          old_r   <= old_eval;
          sched_r <= first_r - ent_eff.saved_first_tx;
          retx_r  <= retx_in_r - ent_eff.saved_retx;
          if (frame_diff < update_interval) begin
            // Inside the interval: report, write back only the first-use init
            res_mcs <= old_eval;
            res_upd <= 1'b0;
            res_avg <= ent_eff.bler;
            state   <= ST_WRITE;
          end else begin
            state   <= ST_PREP;
          end
        end
        ST_PREP: begin
          if (sched_r == '0) begin
            win_r <= ent_r.bler;
            state <= ST_MUL_A;
          end else if (retx_r >= sched_r) begin
            win_r <= bmla_pkg::BLER_FULL;
            state <= ST_MUL_A;
          end else begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            win_r <= div_q;
            state <= ST_MUL_A;
          end
        end
        ST_MUL_A: begin
          prod_r <= {1'b0, mul_a};
          state  <= ST_MUL_B;
        end
        ST_MUL_B: begin
          acc_r  <= prod_r;
          prod_r <= mul_b;
          state  <= ST_SUM;
        end
        ST_SUM: begin
          acc_r <= acc_r + prod_r + bmla_pkg::Q16_ROUND;
          state <= ST_DECIDE;
        end
        ST_DECIDE: begin
          ent_r.bler           <= avg_new;
          ent_r.upd_frame      <= frame_r;
          ent_r.mcs            <= mcs_new;
          ent_r.saved_first_tx <= first_r;
          ent_r.saved_retx     <= retx_in_r;
          res_mcs              <= mcs_new;
          res_upd              <= 1'b1;
          res_avg              <= avg_new;
          state                <= ST_WRITE;
        end
        ST_WRITE: begin
          // Hold until the output register is free; write back on the same edge
          if (out_free) begin
            chosen_mcs   <= res_mcs;
            was_updated  <= res_upd;
            bler_average <= res_avg;
            state        <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  bmla_link_ram #(
    .DEPTH (NUM_LINKS),
    .AW    (SW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  bmla_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (retx_r),
    .divisor  (sched_r),
    .done     (div_done),
    .quotient (div_q)
  );

endmodule

// ----- sv/bmla_link_ram.sv -----
// Per-link state memory: one write port, one read port, registered read data.
`timescale 1ns / 1ps

module bmla_link_ram #(
  parameter int DEPTH = bmla_pkg::NUM_LINKS_DEFAULT,
  parameter int AW    = 6
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [AW-1:0]         waddr,
  input  bmla_pkg::link_entry_t wdata,
  input  logic [AW-1:0]         raddr,
  output bmla_pkg::link_entry_t rdata
);

  bmla_pkg::link_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/bmla_div.sv -----
// Restoring divider: 16-bit fraction of dividend over divisor, one bit per cycle.
`timescale 1ns / 1ps

module bmla_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [bmla_pkg::CNT_W-1:0]    dividend,   // must be below divisor
  input  logic [bmla_pkg::CNT_W-1:0]    divisor,
  output logic                          done,
  output logic [bmla_pkg::BLER_W-1:0]   quotient
);

  localparam int STEP_W = $clog2(bmla_pkg::DIV_STEPS);

  logic                         busy;
  logic [STEP_W-1:0]            step;
  logic [bmla_pkg::CNT_W-1:0]   rem;
  logic [bmla_pkg::CNT_W:0]     shifted;
  logic [bmla_pkg::CNT_W:0]     diff;
  logic                         fits;

  always_comb begin
    shifted = {rem, 1'b0};
    diff    = shifted - {1'b0, divisor};
    fits    = (shifted >= {1'b0, divisor});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        step     <= '0;
        rem      <= dividend;
        quotient <= '0;
      end else if (busy) begin
        rem      <= fits ? diff[bmla_pkg::CNT_W-1:0] : shifted[bmla_pkg::CNT_W-1:0];
        quotient <= {quotient[bmla_pkg::BLER_W-2:0], fits};
        step     <= step + 1'b1;
        if (step == STEP_W'(bmla_pkg::DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- sv/bmla_checker.sv -----
// Port-level checker for the MCS link adaptation block, bound to the top level.
`timescale 1ns / 1ps

module bmla_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [bmla_pkg::MCS_W-1:0]       chosen_mcs,
  input logic                             was_updated,
  input logic [bmla_pkg::BLER_W-1:0]      bler_average
);

  // Transactions accepted but not yet delivered
  logic [1:0] pending;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 2'(in_valid && in_ready) - 2'(out_valid && out_ready);
    end
  end

  a_clear_after_reset: assert property (@(posedge clk)
    $past(rst) && !rst |-> !in_ready)
    else $error("input taken during the memory clearing pass");

  a_no_invented_result: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pending != 2'd0)
    else $error("result shown without an accepted transaction");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> pending <= 2'd1)
    else $error("input taken while a transaction is still in work");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(chosen_mcs) &&
                                $stable(was_updated) && $stable(bler_average))
    else $error("stalled result changed");

endmodule

bind bler_mcs_link_adaptation bmla_checker u_bmla_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .chosen_mcs   (chosen_mcs),
  .was_updated  (was_updated),
  .bler_average (bler_average)
);
